>>> src/cobsfr_pkg.sv
package cobsfr_pkg;

  localparam int CFG_W               = 13;
  localparam int FRAME_COUNT_BITS_DEF = 13;
  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 13'd4096;

  localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
  localparam logic [2:0] KIND_GOOD      = 3'd1;
  localparam logic [2:0] KIND_MISMATCH  = 3'd2;
  localparam logic [2:0] KIND_SYNC      = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd4;
  localparam logic [2:0] KIND_MALFORMED = 3'd5;

  localparam logic [7:0] SUM_INIT = 8'hFF;

  typedef struct packed {
    logic       init;
    logic       add;
    logic [7:0] data;
  } fletcher_ctl_t;

  // end-around carry: keeps a nonzero sum in 1..255
  function automatic logic [7:0] fold(input logic [8:0] s);
    fold = s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

>>> src/cobs_frame_receiver_fletcher16.sv
// COBS frame receiver with Fletcher-16 check.
// The result of an input transfer is registered in the output register in the cycle after the transfer.
// Throughput: 1 byte per cycle; the output register stalls input only while full
//   and out_tready is low.
// Reset (rst_n low, synchronous): hunting for the opening zero, sums at 0xFF,
//   max_frame_bytes back to 4096, output register empty.
module cobs_frame_receiver_fletcher16 #(
  parameter int FRAME_COUNT_BITS = cobsfr_pkg::FRAME_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] payload_byte
  output logic [2:0]                   out_tuser,  // [2:0] kind
  output logic                         out_tlast,  // frame_last
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cobsfr_pkg::CFG_W-1:0] cfg_data    // max_frame_bytes
);
  import cobsfr_pkg::*;

  localparam logic PH_HUNT  = 1'b0;
  localparam logic PH_FRAME = 1'b1;
  localparam int   CMP_W    = (FRAME_COUNT_BITS > CFG_W) ? FRAME_COUNT_BITS : CFG_W;

  logic [CFG_W-1:0]            max_frame_r;
  logic                        phase_r, phase_nxt;
  logic [7:0]                  run_left_r, run_left_nxt;
  logic                        pcf_r, pcf_nxt;
  logic [7:0]                  hb0_r, hb0_nxt, hb1_r, hb1_nxt;
  logic [1:0]                  fill_r, fill_nxt;
  logic [FRAME_COUNT_BITS-1:0] count_r, count_nxt;

  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic [2:0]                  out_kind_r;

  logic                        in_acc;
  logic                        ev_valid;
  logic [2:0]                  ev_kind;
  logic                        open_en;
  logic                        push_en;
  logic [7:0]                  push_data;
  logic                        res_valid;
  logic [7:0]                  res_byte;
  logic [2:0]                  res_kind;
  logic                        overflow;
  fletcher_ctl_t               fl_ctl;
  logic [7:0]                  sum_low, sum_high;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign overflow = (CMP_W'(count_r) >= CMP_W'(max_frame_r)) || (&count_r);

  // frame control
  always_comb begin
    phase_nxt    = phase_r;
    run_left_nxt = run_left_r;
    pcf_nxt      = pcf_r;
    count_nxt    = count_r;
    ev_valid     = 1'b0;
    ev_kind      = KIND_PAYLOAD;
    push_en      = 1'b0;
    push_data    = 8'd0;
    open_en      = 1'b0;
    if (in_acc) begin
      if (phase_r == PH_HUNT) begin
        if (in_tdata == 8'd0) begin
          phase_nxt    = PH_FRAME;
          run_left_nxt = 8'd0;
          pcf_nxt      = 1'b1;
          count_nxt    = FRAME_COUNT_BITS'(1);
          open_en      = 1'b1;
        end else begin
          ev_valid = 1'b1;
          ev_kind  = KIND_SYNC;
        end
      end else if (overflow) begin
        phase_nxt = PH_HUNT;
        ev_valid  = 1'b1;
        ev_kind   = KIND_OVERFLOW;
      end else begin
        count_nxt = count_r + FRAME_COUNT_BITS'(1);
        if (in_tdata == 8'd0) begin
          phase_nxt = PH_HUNT;
          ev_valid  = 1'b1;
          if (run_left_r != 8'd0 || fill_r != 2'd2) begin
            ev_kind = KIND_MALFORMED;
          end else if ({hb0_r, hb1_r} == {sum_high, sum_low}) begin
            ev_kind = KIND_GOOD;
          end else begin
            ev_kind = KIND_MISMATCH;
          end
        end else if (run_left_r == 8'd0) begin
          run_left_nxt = in_tdata - 8'd1;
          pcf_nxt      = (in_tdata == 8'hFF);
          push_en      = !pcf_r;
        end else begin
          run_left_nxt = run_left_r - 8'd1;
          push_en      = 1'b1;
          push_data    = in_tdata;
        end
      end
    end
  end

  // two-byte holdback
  always_comb begin
    hb0_nxt     = hb0_r;
    hb1_nxt     = hb1_r;
    fill_nxt    = fill_r;
    fl_ctl.init = open_en;
    fl_ctl.add  = 1'b0;
    fl_ctl.data = hb0_r;
    res_valid   = ev_valid;
    res_kind    = ev_kind;
    res_byte    = 8'd0;
    if (open_en) begin
      hb0_nxt  = 8'd0;
      hb1_nxt  = 8'd0;
      fill_nxt = 2'd0;
    end else if (push_en) begin
      unique case (fill_r)
        2'd0: begin
          hb0_nxt  = push_data;
          fill_nxt = 2'd1;
        end
        2'd1: begin
          hb1_nxt  = push_data;
          fill_nxt = 2'd2;
        end
        default: begin
          hb0_nxt    = hb1_r;
          hb1_nxt    = push_data;
          fl_ctl.add = 1'b1;
          res_valid  = 1'b1;
          res_kind   = KIND_PAYLOAD;
          res_byte   = hb0_r;
        end
      endcase
    end
  end

  cobsfr_fletcher u_fletcher (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fl_ctl),
    .sum_low  (sum_low),
    .sum_high (sum_high)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RESET;
      phase_r     <= PH_HUNT;
      run_left_r  <= 8'd0;
      pcf_r       <= 1'b1;
      hb0_r       <= 8'd0;
      hb1_r       <= 8'd0;
      fill_r      <= 2'd0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_frame_r <= cfg_data;
      end
      phase_r    <= phase_nxt;
      run_left_r <= run_left_nxt;
      pcf_r      <= pcf_nxt;
      hb0_r      <= hb0_nxt;
      hb1_r      <= hb1_nxt;
      fill_r     <= fill_nxt;
      count_r    <= count_nxt;
      if (in_tready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      out_byte_r <= res_byte;
      out_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = (out_kind_r != KIND_PAYLOAD);

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3) else $error("holdback fill out of range");
  a_sync_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_HUNT && in_tdata != 8'd0
    |=> out_tvalid && out_tuser == KIND_SYNC)
    else $error("missing out-of-sync result");
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_HUNT && in_tdata == 8'd0
    |=> phase_r == PH_FRAME && count_r == FRAME_COUNT_BITS'(1) && fill_r == 2'd0)
    else $error("frame open state wrong");
  a_payload_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid && res_kind == KIND_PAYLOAD |-> fill_r == 2'd2)
    else $error("payload left holdback before it was full");

endmodule

>>> src/cobsfr_fletcher.sv
module cobsfr_fletcher (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cobsfr_pkg::fletcher_ctl_t ctl,
  output logic [7:0]             sum_low,
  output logic [7:0]             sum_high
);
  import cobsfr_pkg::*;

  logic [7:0] sum_low_r, sum_low_nxt;
  logic [7:0] sum_high_r, sum_high_nxt;
  logic [7:0] low_step;

  always_comb begin
    low_step     = fold({1'b0, sum_low_r} + {1'b0, ctl.data});
    sum_low_nxt  = sum_low_r;
    sum_high_nxt = sum_high_r;
    if (ctl.init) begin
      sum_low_nxt  = SUM_INIT;
      sum_high_nxt = SUM_INIT;
    end else if (ctl.add) begin
      sum_low_nxt  = low_step;
      sum_high_nxt = fold({1'b0, sum_high_r} + {1'b0, low_step});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_low_r  <= SUM_INIT;
      sum_high_r <= SUM_INIT;
    end else begin
      sum_low_r  <= sum_low_nxt;
      sum_high_r <= sum_high_nxt;
    end
  end

  assign sum_low  = sum_low_r;
  assign sum_high = sum_high_r;

  a_low_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sum_low_r != 8'd0) else $error("fletcher low sum reached zero");
  a_high_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sum_high_r != 8'd0) else $error("fletcher high sum reached zero");
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.init |=> sum_low_r == SUM_INIT && sum_high_r == SUM_INIT)
    else $error("fletcher init not applied");

endmodule
